@@ hdl/lde_pkg.sv @@
`default_nettype none

package lde_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7fff_ffff;

    typedef enum logic [1:0] {
        CMD_APPEND    = 2'd0,
        CMD_DEL_VALUE = 2'd1,
        CMD_DEL_MIN   = 2'd2,
        CMD_DEL_RANGE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MIN_RD,
        S_MIN_CHK,
        S_TAIL_WR,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic min_init;
        logic min_read;
        logic min_adv;
        logic tail_read;
        logic tail_wr;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_is_append;
        logic list_empty;
        logic is_min;
        logic scan_done;
        logic i_lt_n;
        logic hit;
        logic tail_more;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/lde_req_if.sv @@
`default_nettype none

interface lde_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic signed [31:0]         value;
    logic signed [31:0]         range_high;

    modport source (output valid, cmd, value, range_high, input ready);
    modport sink   (input valid, cmd, value, range_high, output ready);
endinterface

`default_nettype wire

@@ hdl/lde_rsp_if.sv @@
`default_nettype none

interface lde_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [4:0]                 length;
    logic signed [31:0]         minimum;
    logic [4:0]                 removed;

    modport source (output valid, status, length, minimum, removed, input ready);
    modport sink   (input valid, status, length, minimum, removed, output ready);
endinterface

`default_nettype wire

@@ hdl/lde_ram.sv @@
`default_nettype none

// simple dual port, registered read, read returns old data on collision
module lde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/lde_ctrl.sv @@
`default_nettype none

module lde_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire lde_pkg::dp_stat_t stat,
    output lde_pkg::dp_cmd_t      cmd
);

    lde_pkg::state_t state_reg;
    lde_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lde_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            lde_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.req_is_append || stat.list_empty)
                    begin
                        state_next = lde_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = lde_pkg::S_SCAN;
                    end
                end
            end
            lde_pkg::S_SCAN:
            begin
                if (!stat.scan_done)
                begin
                    cmd.scan = 1'b1;
                end
                else if (stat.is_min)
                begin
                    cmd.min_init = 1'b1;
                    state_next   = lde_pkg::S_MIN_RD;
                end
                else
                begin
                    state_next = lde_pkg::S_FINISH;
                end
            end
            lde_pkg::S_MIN_RD:
            begin
                if (stat.i_lt_n)
                begin
                    cmd.min_read = 1'b1;
                    state_next   = lde_pkg::S_MIN_CHK;
                end
                else
                begin
                    state_next = lde_pkg::S_FINISH;
                end
            end
            lde_pkg::S_MIN_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.tail_read = 1'b1;
                    state_next    = lde_pkg::S_TAIL_WR;
                end
                else
                begin
                    cmd.min_adv = 1'b1;
                    state_next  = lde_pkg::S_MIN_RD;
                end
            end
            lde_pkg::S_TAIL_WR:
            begin
                cmd.tail_wr = 1'b1;
                if (!stat.tail_more)
                begin
                    state_next = lde_pkg::S_FINISH;
                end
                else if (!stat.hit)
                begin
                    cmd.min_adv = 1'b1;
                    state_next  = lde_pkg::S_MIN_RD;
                end
            end
            lde_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = lde_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lde_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != lde_pkg::S_IDLE)
        else $error("accepted beat did not start a command");

    a_finish_commits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lde_pkg::S_FINISH && stat.out_free |=> state_reg == lde_pkg::S_IDLE)
        else $error("finish did not return to idle with free output");

endmodule

`default_nettype wire

@@ hdl/lde_datapath.sv @@
`default_nettype none

module lde_datapath #(
    parameter int CAPACITY = lde_pkg::CAPACITY_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lde_pkg::dp_cmd_t         cmd,
    output lde_pkg::dp_stat_t             stat,
    input  wire logic [1:0]               req_cmd,
    input  wire logic signed [31:0]       req_value,
    input  wire logic signed [31:0]       req_range_high,
    input  wire logic                     rsp_ready,
    output logic                          rsp_valid,
    output lde_pkg::status_t              rsp_status,
    output logic [4:0]                    rsp_length,
    output logic signed [31:0]            rsp_minimum,
    output logic [4:0]                    rsp_removed
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int DW = lde_pkg::DATA_W;
    localparam int LW = lde_pkg::LEN_W;

    // list state
    logic [CW-1:0]          count_reg, count_next;

    // per-command working registers
    lde_pkg::cmd_t          op_reg, op_next;
    logic signed [DW-1:0]   lo_reg, lo_next;
    logic signed [DW-1:0]   hi_reg, hi_next;
    logic [CW-1:0]          rd_reg, rd_next;
    logic [CW-1:0]          wr_reg, wr_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          removed_reg, removed_next;
    logic signed [DW-1:0]   min_reg, min_next;
    logic                   pend_reg, pend_next;
    logic                   full_reg, full_next;
    logic                   empty_reg, empty_next;

    // result register
    logic                   rsp_valid_reg, rsp_valid_next;
    lde_pkg::status_t       rsp_status_reg, rsp_status_next;
    logic [LW-1:0]          rsp_length_reg, rsp_length_next;
    logic signed [DW-1:0]   rsp_minimum_reg, rsp_minimum_next;
    logic [LW-1:0]          rsp_removed_reg, rsp_removed_next;

    // ram port
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DW-1:0]          ram_rdata;
    logic signed [DW-1:0]   rd_val;

    logic [CW-1:0]          n_m1, n_m2;
    logic                   keep;
    logic [CW+LW-1:0]       len_ext;
    logic [CW+LW-1:0]       rem_ext;
    logic [CW-1:0]          rem_val;

    lde_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val = $signed(ram_rdata);
    assign n_m1   = n_reg - CW'(1);
    assign n_m2   = n_reg - CW'(2);
    assign keep   = !((rd_val >= lo_reg) && (rd_val <= hi_reg));

    assign stat.req_is_append = (lde_pkg::cmd_t'(req_cmd) == lde_pkg::CMD_APPEND);
    assign stat.list_empty    = (count_reg == '0);
    assign stat.is_min        = (op_reg == lde_pkg::CMD_DEL_MIN);
    assign stat.scan_done     = (rd_reg >= n_reg) && !pend_reg;
    assign stat.i_lt_n        = (rd_reg < n_reg);
    assign stat.hit           = (rd_val == min_reg);
    assign stat.tail_more     = ((rd_reg + CW'(1)) < n_reg);
    assign stat.out_free      = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        count_next       = count_reg;
        op_next          = op_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        n_next           = n_reg;
        removed_next     = removed_reg;
        min_next         = min_reg;
        pend_next        = 1'b0;
        full_next        = full_reg;
        empty_next       = empty_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_status_next  = rsp_status_reg;
        rsp_length_next  = rsp_length_reg;
        rsp_minimum_next = rsp_minimum_reg;
        rsp_removed_next = rsp_removed_reg;
        ram_we           = 1'b0;
        ram_waddr        = wr_reg[AW-1:0];
        ram_wdata        = ram_rdata;
        ram_raddr        = rd_reg[AW-1:0];
        rem_val          = '0;

        if (cmd.load)
        begin
            op_next      = lde_pkg::cmd_t'(req_cmd);
            lo_next      = req_value;
            hi_next      = (lde_pkg::cmd_t'(req_cmd) == lde_pkg::CMD_DEL_RANGE) ?
                           req_range_high : req_value;
            rd_next      = '0;
            wr_next      = '0;
            n_next       = count_reg;
            removed_next = '0;
            min_next     = lde_pkg::EMPTY_MIN;
            full_next    = (count_reg == CW'(CAPACITY));
            empty_next   = (count_reg == '0);
        end

        // streaming pass: issue reads, consume the data once the RAM returns it
        if (cmd.scan && (rd_reg < n_reg))
        begin
            rd_next   = rd_reg + CW'(1);
            pend_next = 1'b1;
        end
        if (pend_reg)
        begin
            if (op_reg == lde_pkg::CMD_DEL_MIN)
            begin
                if (rd_val < min_reg)
                begin
                    min_next = rd_val;
                end
            end
            else if (keep)
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                wr_next   = wr_reg + CW'(1);
            end
            else
            begin
                removed_next = removed_reg + CW'(1);
            end
        end

        if (cmd.min_init)
        begin
            rd_next = '0;
        end
        if (cmd.tail_read)
        begin
            ram_raddr = n_m1[AW-1:0];
        end
        // fill the hole with the tail value, prefetch the new tail
        if (cmd.tail_wr)
        begin
            ram_we       = 1'b1;
            ram_waddr    = rd_reg[AW-1:0];
            ram_wdata    = ram_rdata;
            ram_raddr    = n_m2[AW-1:0];
            n_next       = n_m1;
            removed_next = removed_reg + CW'(1);
        end
        if (cmd.min_adv)
        begin
            rd_next = rd_reg + CW'(1);
        end

        if (cmd.commit)
        begin
            rsp_valid_next   = 1'b1;
            rsp_status_next  = lde_pkg::STAT_OK;
            rsp_minimum_next = lde_pkg::EMPTY_MIN;
            if (op_reg == lde_pkg::CMD_APPEND)
            begin
                if (full_reg)
                begin
                    rsp_status_next = lde_pkg::STAT_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[AW-1:0];
                    ram_wdata  = lo_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            else if (empty_reg)
            begin
                rsp_status_next = lde_pkg::STAT_EMPTY;
            end
            else if (op_reg == lde_pkg::CMD_DEL_MIN)
            begin
                count_next       = n_reg;
                rem_val          = removed_reg;
                rsp_minimum_next = min_reg;
            end
            else
            begin
                count_next = wr_reg;
                rem_val    = removed_reg;
            end
            rsp_length_next  = len_ext[LW-1:0];
            rsp_removed_next = rem_ext[LW-1:0];
        end
    end

    assign len_ext = {{LW{1'b0}}, count_next};
    assign rem_ext = {{LW{1'b0}}, rem_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            n_reg         <= '0;
            removed_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            n_reg         <= n_next;
            removed_reg   <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        min_reg         <= min_next;
        full_reg        <= full_next;
        empty_reg       <= empty_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_length_reg  <= rsp_length_next;
        rsp_minimum_reg <= rsp_minimum_next;
        rsp_removed_reg <= rsp_removed_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_status  = rsp_status_reg;
    assign rsp_length  = rsp_length_reg;
    assign rsp_minimum = rsp_minimum_reg;
    assign rsp_removed = rsp_removed_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= rd_reg)
        else $error("compaction write pointer passed read pointer");

    a_removed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (op_reg != lde_pkg::CMD_APPEND) && !empty_reg
        |-> (removed_reg <= CW'(CAPACITY)) && (n_reg <= CW'(CAPACITY)))
        else $error("removed count out of range at commit");

endmodule

`default_nettype wire

@@ hdl/list_delete_by_value_engine.sv @@
// Ordered list engine holding up to CAPACITY signed 32-bit entries in a
// single simple-dual-port RAM. One request beat in gives exactly one
// response beat out. Append stores at the tail (status full and no change
// when the list is full); delete-value and delete-range remove matching
// entries while keeping order; delete-min removes every copy of the
// smallest entry, filling each hole with the current last entry, and
// reports that minimum. Deletes on an empty list answer status empty.
// Append and any delete on an empty list go straight from accept to the
// finish state. Delete-value and delete-range stream the list once
// through the RAM read port. Delete-min streams once to find the minimum,
// then revisits entries, reading and checking each slot visited and
// writing the tail into the hole for each removed copy. All work
// serializes on the single RAM read port. A new request is taken while the
// previous response is still waiting in the output register.
`default_nettype none

module list_delete_by_value_engine #(
    parameter int CAPACITY = lde_pkg::CAPACITY_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lde_req_if.sink     req,
    lde_rsp_if.source   rsp
);

    // command and status bundles between controller and datapath
    lde_pkg::dp_cmd_t  dp_cmd;
    lde_pkg::dp_stat_t dp_stat;
    lde_pkg::status_t  rsp_status;

    // sequencer: one command at a time, drives request ready
    lde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // list storage, pointers, compare logic and the response register
    lde_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .req_cmd        (req.cmd),
        .req_value      (req.value),
        .req_range_high (req.range_high),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp_status),
        .rsp_length     (rsp.length),
        .rsp_minimum    (rsp.minimum),
        .rsp_removed    (rsp.removed)
    );

    // status code onto the plain response bus
    assign rsp.status = rsp_status;

endmodule

`default_nettype wire

@@ tb/list_check_pkg.sv @@
`timescale 1ns / 100ps

package list_check_pkg;

    import lde_pkg::*;

    typedef struct {
        status_t                  status;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] minimum;
        logic [LEN_W-1:0]         removed;
    } list_reply_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] slots [CAPACITY_DEF];
        int unsigned              fill;
        list_reply_t              pending_replies[$];
        int unsigned              mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // drop every entry in [lo, hi], survivors keep their order
        function int unsigned drop_span(logic signed [DATA_W-1:0] lo,
                                        logic signed [DATA_W-1:0] hi);
            int unsigned kept;
            int unsigned old_fill;
            int unsigned k;
            kept     = 0;
            old_fill = fill;
            for (k = 0; k < old_fill; k++)
            begin
                if (!(slots[k] >= lo && slots[k] <= hi))
                begin
                    slots[kept] = slots[k];
                    kept++;
                end
            end
            fill = kept;
            return old_fill - kept;
        endfunction

        // apply one accepted command and queue the reply it must produce
        function void note_command(cmd_t cmd, logic signed [DATA_W-1:0] value,
                                   logic signed [DATA_W-1:0] upper);
            list_reply_t              r;
            int unsigned              cut;
            int unsigned              n;
            int unsigned              k;
            logic signed [DATA_W-1:0] low;
            r.status  = STAT_OK;
            r.minimum = EMPTY_MIN;
            cut       = 0;
            if (cmd == CMD_APPEND)
            begin
                if (fill < CAPACITY_DEF)
                begin
                    slots[fill] = value;
                    fill++;
                end
                else
                    r.status = STAT_FULL;
            end
            else if (fill == 0)
                r.status = STAT_EMPTY;
            else if (cmd == CMD_DEL_VALUE)
                cut = drop_span(value, value);
            else if (cmd == CMD_DEL_RANGE)
                cut = drop_span(value, upper);
            else
            begin
                n   = fill;
                low = slots[0];
                for (k = 1; k < n; k++)
                    if (slots[k] < low)
                        low = slots[k];
                // each hole takes the last entry, then gets checked again
                k = 0;
                while (k < n)
                begin
                    if (slots[k] == low)
                    begin
                        slots[k] = slots[n-1];
                        n--;
                        cut++;
                    end
                    else
                        k++;
                end
                fill      = n;
                r.minimum = low;
            end
            r.length  = LEN_W'(fill);
            r.removed = LEN_W'(cut);
            pending_replies.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void check_reply(logic [1:0] status, logic [LEN_W-1:0] length,
                                  logic signed [DATA_W-1:0] minimum,
                                  logic [LEN_W-1:0] removed);
            list_reply_t e;
            if (pending_replies.size() == 0)
            begin
                flag($sformatf("reply st=%0d len=%0d min=%0d rm=%0d with none pending",
                               status, length, minimum, removed));
                return;
            end
            e = pending_replies.pop_front();
            if (status !== e.status || length !== e.length ||
                minimum !== e.minimum || removed !== e.removed)
                flag($sformatf("exp st=%0d len=%0d min=%0d rm=%0d, got st=%0d len=%0d min=%0d rm=%0d",
                               e.status, e.length, e.minimum, e.removed,
                               status, length, minimum, removed));
        endfunction
    endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import lde_pkg::*;
    import list_check_pkg::*;

    // cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT  = 4000;
    // long receiver hold-off, long enough to back the block up to its input
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 64;

    logic clk;
    logic rst_n;

    lde_req_if req_ch ();
    lde_rsp_if rsp_ch ();

    list_delete_by_value_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard sb;

    int unsigned replies_seen;
    int unsigned quiet_cycles;
    int unsigned burst_left;
    bit          holding;

    // small pool of values so deletes actually hit stored entries
    logic signed [31:0] pool [8];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mix of full-width noise, the two extremes and values near zero
    function automatic logic signed [31:0] fresh_value();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh8000_0000;
            default: return 32'($urandom_range(0, 16)) - 32'd8;
        endcase
    endfunction

    function automatic void refresh_pool();
        for (int k = 0; k < 8; k++)
            pool[k] = fresh_value();
    endfunction

    function automatic logic signed [31:0] pool_value();
        if ($urandom_range(0, 9) < 8)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // choose the next command, steering by how full the list is so that
    // appends, full-list drops and deletes on busy lists all get exercised
    function automatic void pick_command(output cmd_t c,
                                         output logic signed [31:0] v,
                                         output logic signed [31:0] h);
        int unsigned append_pct;
        int unsigned roll;
        if (sb.fill == 0)
            append_pct = 85;
        else if (sb.fill == CAPACITY_DEF)
            append_pct = 15;
        else
            append_pct = 55;
        roll = $urandom_range(0, 99);
        v    = pool_value();
        h    = $urandom;
        if (roll < append_pct)
            c = CMD_APPEND;
        else
        begin
            case ($urandom_range(0, 2))
                0: c = CMD_DEL_VALUE;
                1: c = CMD_DEL_MIN;
                default:
                begin
                    c    = CMD_DEL_RANGE;
                    roll = $urandom_range(0, 19);
                    if (roll < 3)
                        h = v - 32'($urandom_range(1, 20));    // inverted range
                    else if (roll < 5)
                        v = $urandom;                          // wide noise range
                    else
                        h = v + 32'($urandom_range(0, 12));
                end
            endcase
        end
    endfunction

    // offer one command beat and hold it until the block takes it;
    // idle gaps fall between bursts, never while the receiver is held off
    task automatic offer(cmd_t c, logic signed [31:0] v, logic signed [31:0] h);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (!holding && $urandom_range(0, 3) != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.cmd        <= c;
        req_ch.value      <= v;
        req_ch.range_high <= h;
        req_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_command(c, v, h);
    endtask

    // sender: reset, directed corner cases, then the random stream
    initial
    begin
        logic signed [31:0] fill_vals [16];
        cmd_t               c;
        logic signed [31:0] v;
        logic signed [31:0] h;

        sb         = new();
        burst_left = 0;
        holding    = 1'b0;
        fill_vals  = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1,
                       32'sh5555_5555, 32'shaaaa_aaaa, 32'sd5, 32'sd5,
                       32'sh8000_0000, 32'sd5, 32'sd1, 32'sd2,
                       -32'sd5, 32'sd100, 32'sd5, 32'sh7fff_ffff};

        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_APPEND;
        req_ch.value      <= '0;
        req_ch.range_high <= '0;
        rst_n             <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every delete on an empty list
        offer(CMD_DEL_VALUE, 32'sd0, 32'sd0);
        offer(CMD_DEL_MIN, 32'sh7fff_ffff, 32'sh8000_0000);
        offer(CMD_DEL_RANGE, 32'sh8000_0000, 32'sh7fff_ffff);
        // fill to capacity with extremes, alternating bits and duplicates
        foreach (fill_vals[k])
            offer(CMD_APPEND, fill_vals[k], 32'shffff_ffff);
        // append on a full list is dropped
        offer(CMD_APPEND, 32'sd42, 32'sd0);
        // delete that matches nothing
        offer(CMD_DEL_VALUE, 32'sd77, 32'sh5555_5555);
        // delete of a value stored several times
        offer(CMD_DEL_VALUE, 32'sd5, 32'shaaaa_aaaa);
        // inverted range removes nothing
        offer(CMD_DEL_RANGE, 32'sd10, -32'sd10);
        // minimum present twice, at the most negative value
        offer(CMD_DEL_MIN, 32'sd0, 32'sd0);
        // range covering everything empties the list
        offer(CMD_DEL_RANGE, 32'sh8000_0000, 32'sh7fff_ffff);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                refresh_pool();
            pick_command(c, v, h);
            offer(c, v, h);
        end
        req_ch.valid <= 1'b0;

        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        // let any stray reply show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: stall pattern switching between modes, plus one long hold-off
    // once traffic is under way so the block backs up and stalls its input
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        bit          hold_done;

        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_done && replies_seen >= HOLD_AFTER)
            begin
                holding = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding   = 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // reply monitor: each accepted reply beat is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            sb.check_reply(rsp_ch.status, rsp_ch.length, rsp_ch.minimum, rsp_ch.removed);
            replies_seen++;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

endmodule
